[hw/rtl/mts_pkg.sv]
// mts_pkg: shared sizes, operation and status codes, sequencer states and
// the memory request struct of the min tracking stack
// depends on nothing
package mts_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_e;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] val_wdata;
    logic [DATA_WIDTH-1:0] min_wdata;
    logic                  re;
    logic [ADDR_W-1:0]     val_raddr;
    logic [ADDR_W-1:0]     min_raddr;
  } mem_req_t;

endpackage

[hw/rtl/mts_ram.sv]
// mts_ram: simple dual port synchronous ram, one write and one registered read
// self contained, no package needed
module mts_ram #(
  parameter int Depth = 64,
  parameter int Width = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[hw/rtl/mts_ctrl.sv]
// mts_ctrl: request sequencer, entry count and result logic of the stack
// depends on mts_pkg; drives the two ram instances through mem_req_t
module mts_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind_i,
  input  logic [mts_pkg::DATA_WIDTH-1:0] push_value_i,
  output mts_pkg::mem_req_t             mem_req_o,
  input  logic [mts_pkg::DATA_WIDTH-1:0] val_rdata_i,
  input  logic [mts_pkg::DATA_WIDTH-1:0] min_rdata_i,
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic [mts_pkg::DATA_WIDTH-1:0] popped_value_o,
  output logic                          min_valid_o,
  output logic [mts_pkg::DATA_WIDTH-1:0] min_value_o
);

  import mts_pkg::*;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [1:0]             kind_q, kind_d;
  logic [DATA_WIDTH-1:0]  value_q, value_d;
  logic [CNT_W-1:0]       cnt_m1, cnt_m2;
  logic                   is_empty, is_full;
  logic signed [DATA_WIDTH-1:0] top_min, push_v;
  logic [DATA_WIDTH-1:0]  new_min;

  assign cnt_m1   = count_q - CNT_W'(1);
  assign cnt_m2   = count_q - CNT_W'(2);
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign top_min  = $signed(min_rdata_i);
  assign push_v   = $signed(value_q);
  assign new_min  = (!is_empty && (top_min < push_v)) ? min_rdata_i : value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
  end

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    kind_d         = kind_q;
    value_d        = value_q;
    mem_req_o      = '0;
    busy           = 1'b0;
    valid_o        = 1'b0;
    status_o       = ST_OK;
    popped_value_o = '0;
    min_valid_o    = 1'b0;
    min_value_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        // top entry reads; a pop also needs the minimum one below the top
        mem_req_o.val_raddr = cnt_m1[ADDR_W-1:0];
        mem_req_o.min_raddr = (kind_i == KIND_POP) ? cnt_m2[ADDR_W-1:0]
                                                   : cnt_m1[ADDR_W-1:0];
        if (start) begin
          mem_req_o.re = 1'b1;
          kind_d       = kind_i;
          value_d      = push_value_i;
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        busy    = 1'b1;
        valid_o = 1'b1;
        state_d = S_IDLE;
        case (kind_q)
          KIND_PUSH: begin
            if (is_full) begin
              status_o    = ST_FULL;
              min_valid_o = 1'b1;
              min_value_o = min_rdata_i;
            end else begin
              mem_req_o.we        = 1'b1;
              mem_req_o.waddr     = count_q[ADDR_W-1:0];
              mem_req_o.val_wdata = value_q;
              mem_req_o.min_wdata = new_min;
              count_d             = count_q + CNT_W'(1);
              min_valid_o         = 1'b1;
              min_value_o         = new_min;
            end
          end
          KIND_POP: begin
            if (is_empty) begin
              status_o = ST_EMPTY;
            end else begin
              count_d        = cnt_m1;
              popped_value_o = val_rdata_i;
              if (count_q > CNT_W'(1)) begin
                min_valid_o = 1'b1;
                min_value_o = min_rdata_i;
              end
            end
          end
          KIND_QUERY: begin
            if (is_empty) begin
              status_o = ST_EMPTY;
            end else begin
              min_valid_o = 1'b1;
              min_value_o = min_rdata_i;
            end
          end
          default: begin
            // unused code: no change, report current minimum
            if (!is_empty) begin
              min_valid_o = 1'b1;
              min_value_o = min_rdata_i;
            end
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/min_tracking_stack_core.sv]
// min_tracking_stack_core: top level of the min tracking stack
// depends on mts_pkg, mts_ctrl and mts_ram
//
// usage
// - request channel: kind_i (0 push, 1 pop, 2 query minimum) and push_value_i,
//   taken at a rising edge where start is high and busy is low
// - result channel: valid_o strobes for exactly one cycle with status_o,
//   popped_value_o, min_valid_o and min_value_o; the receiver cannot stall,
//   so a result must be captured in that cycle
// - latency: the result appears in the cycle after the request is taken
// - sequencing: a request first reads the top entry from the two rams
//   (registered read), then computes the result and, on a push, writes the
//   new entry back, with busy high to hold off the next request
// - every entry keeps its value and the running minimum of itself and all
//   entries below, so the top running minimum is the stack minimum
// - reset clears only the entry count and the sequencer; ram contents
//   at or above the count never reach a result, so no clearing pass is needed
// - empty pop or query and full push are flagged and change nothing
module min_tracking_stack_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     kind_i,
  input  logic [mts_pkg::DATA_WIDTH-1:0] push_value_i,
  output logic                           valid_o,
  output logic [1:0]                     status_o,
  output logic [mts_pkg::DATA_WIDTH-1:0] popped_value_o,
  output logic                           min_valid_o,
  output logic [mts_pkg::DATA_WIDTH-1:0] min_value_o
);

  import mts_pkg::*;

  mem_req_t              mem_req;
  logic [DATA_WIDTH-1:0] val_rdata;
  logic [DATA_WIDTH-1:0] min_rdata;

  // sequencer, count and result logic
  mts_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .push_value_i   (push_value_i),
    .mem_req_o      (mem_req),
    .val_rdata_i    (val_rdata),
    .min_rdata_i    (min_rdata),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .min_valid_o    (min_valid_o),
    .min_value_o    (min_value_o)
  );

  // stored values
  mts_ram #(
    .Depth (DEPTH),
    .Width (DATA_WIDTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.val_wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.val_raddr),
    .rdata_o (val_rdata)
  );

  // running minima, written at the same address as the value
  mts_ram #(
    .Depth (DEPTH),
    .Width (DATA_WIDTH)
  ) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.min_wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.min_raddr),
    .rdata_o (min_rdata)
  );

endmodule

[hw/rtl/mts_checker.sv]
// mts_checker: port level assertions for min_tracking_stack_core
// depends on mts_pkg; bound to the top level at the end of this file
module mts_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic [1:0]                     kind_i,
  input logic [mts_pkg::DATA_WIDTH-1:0] push_value_i,
  input logic                           valid_o,
  input logic [1:0]                     status_o,
  input logic [mts_pkg::DATA_WIDTH-1:0] popped_value_o,
  input logic                           min_valid_o,
  input logic [mts_pkg::DATA_WIDTH-1:0] min_value_o
);

  import mts_pkg::*;

  // every taken request gives its result in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> valid_o)
    else $error("no result one cycle after a request");

  // results are never back to back
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("two results in consecutive cycles");

  // empty status reports nothing
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ST_EMPTY)) |->
      (!min_valid_o && (popped_value_o == '0) && (min_value_o == '0)))
    else $error("empty status with data");

  // no minimum means a zero minimum
  a_min_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !min_valid_o) |-> (min_value_o == '0))
    else $error("minimum value without min_valid");

  // full push reports the current minimum and pops nothing
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ST_FULL)) |-> (min_valid_o && (popped_value_o == '0)))
    else $error("full status with wrong fields");

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (.*);
